FILE: src/tbcr_pkg.sv
// Package for the tile map box collision resolver.
// Holds the fixed point constants, codes, pipeline types and the push step function.
// No dependencies.
package tbcr_pkg;

  // Geometry in pixels
  localparam int TILE_SIZE = 64;
  localparam int BOX_SIZE  = 60;
  localparam int BOX_HALF  = 30;
  localparam int MAP_DIM   = 64;

  // Fixed point formats
  localparam int FRAC_BITS  = 8;
  localparam int POS_W      = 21;
  localparam int ACC_W      = 24;
  localparam int DIM_W      = 7;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int TILE_SHIFT = FRAC_BITS + $clog2(TILE_SIZE);

  localparam int BOX_FX       = BOX_SIZE * (1 << FRAC_BITS);
  localparam int HALF_FX      = BOX_HALF * (1 << FRAC_BITS);
  localparam int TILE_HALF_FX = TILE_SIZE * (1 << (FRAC_BITS - 1));
  localparam int MIN_DIST     = HALF_FX + TILE_HALF_FX;
  localparam int OFF_BASE     = HALF_FX - TILE_HALF_FX;
  localparam int POS_MAX      = (1 << (POS_W - 1)) - 1;
  localparam int POS_MIN      = -(1 << (POS_W - 1));
  localparam int CFG_RESET    = 64;

  localparam logic signed [ACC_W-1:0] BOX_FX_A   = ACC_W'(BOX_FX);
  localparam logic signed [ACC_W-1:0] MIN_DIST_A = ACC_W'(MIN_DIST);
  localparam logic signed [ACC_W-1:0] OFF_BASE_A = ACC_W'(OFF_BASE);
  localparam logic signed [ACC_W-1:0] POS_MAX_A  = ACC_W'(POS_MAX);
  localparam logic signed [ACC_W-1:0] POS_MIN_A  = ACC_W'(POS_MIN);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COLUMNS = 1'b0,
    REG_MAP_ROWS    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_WRITE   = 1'b0,
    MODE_RESOLVE = 1'b1
  } mode_t;

  // Tile map write request
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             solid;
  } map_wr_t;

  // Tile map read request: the two box rows
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] row0;
    logic [IDX_W-1:0] row1;
  } map_rd_t;

  // Item after the map read stage
  typedef struct packed {
    logic                    resolve;
    logic signed [ACC_W-1:0] px;
    logic signed [ACC_W-1:0] py;
    logic [IDX_W-1:0]        col0;
    logic [IDX_W-1:0]        col1;
    logic [1:0]              col_ok;
    logic [1:0]              row_ok;
    logic [IDX_W-1:0]        row0;
    logic [IDX_W-1:0]        row1;
  } rd_item_t;

  // Item in the push stages; offsets are box half minus tile centre
  typedef struct packed {
    logic signed [ACC_W-1:0] px;
    logic signed [ACC_W-1:0] py;
    logic [3:0]              hits;
    logic [2:0]              hit_count;
    logic signed [ACC_W-1:0] off_c0;
    logic signed [ACC_W-1:0] off_c1;
    logic signed [ACC_W-1:0] off_r0;
    logic signed [ACC_W-1:0] off_r1;
  } item_t;

  // Push the box out of corner k's tile; the new edge lands on the tile boundary
  function automatic item_t push_step(item_t it, logic [1:0] k);
    item_t                   res;
    logic signed [ACC_W-1:0] offx;
    logic signed [ACC_W-1:0] offy;
    logic signed [ACC_W-1:0] dx;
    logic signed [ACC_W-1:0] dy;
    logic signed [ACC_W-1:0] adx;
    logic signed [ACC_W-1:0] ady;
    res  = it;
    offx = k[0] ? it.off_c1 : it.off_c0;
    offy = k[1] ? it.off_r1 : it.off_r0;
    dx   = it.px + offx;
    dy   = it.py + offy;
    adx  = dx[ACC_W-1] ? -dx : dx;
    ady  = dy[ACC_W-1] ? -dy : dy;
    if (it.hits[k] && (adx < MIN_DIST_A) && (ady < MIN_DIST_A)) begin
      if (adx > ady) begin
        res.px = dx[ACC_W-1] ? (-offx - MIN_DIST_A) : (MIN_DIST_A - offx);
      end else begin
        res.py = dy[ACC_W-1] ? (-offy - MIN_DIST_A) : (MIN_DIST_A - offy);
      end
    end
    return res;
  endfunction

endpackage

FILE: src/tbcr_map_mem.sv
// Tile map memory: MAP_DIM rows of MAP_DIM bits, bit write, two registered row reads.
// Runs a clearing pass over all rows after reset. Depends on tbcr_pkg.
module tbcr_map_mem import tbcr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  map_wr_t            wr,
  input  map_rd_t            rd,
  output logic [MAP_DIM-1:0] rdata0,
  output logic [MAP_DIM-1:0] rdata1,
  output logic               busy
);

  logic [MAP_DIM-1:0] mem [MAP_DIM];
  logic [IDX_W-1:0]   clr_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == IDX_W'(MAP_DIM - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '0;
    end else if (wr.en) begin
      mem[wr.row][wr.col] <= wr.solid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata0 <= mem[rd.row0];
      rdata1 <= mem[rd.row1];
    end
  end

endmodule

FILE: src/tilemap_box_collision_resolve.sv
// Top level of the tile map box collision resolver: config registers, corner
// decode, map read, four push stages and saturating output register.
// Depends on tbcr_pkg and tbcr_map_mem.
//
//   channel  direction  handshake            payload
//   cfg      in         cfg_write            cfg_index, cfg_data
//   in       in         in_valid/in_ready    mode, pos_x, pos_y, tile_*
//   out      out        out_valid/out_ready  new_x, new_y, collided, hit_count
//
// One request per cycle while neither the clearing pass nor a stall at out holds it;
// each result passes the registers map read, hit decode, one per corner push, output.
// After reset a clearing pass zeroes the map one row a cycle, with in_ready low
// until the pass ends. Config writes are taken at any time.
// A stall at out holds every stage back to in_ready; nothing is dropped.
module tilemap_box_collision_resolve import tbcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [IDX_W-1:0]        tile_column,
  input  logic [IDX_W-1:0]        tile_row,
  input  logic                    tile_solid,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] new_x,
  output logic signed [POS_W-1:0] new_y,
  output logic                    collided,
  output logic [2:0]              hit_count
);

  localparam int NPIPE = 5;

  logic [DIM_W-1:0] map_columns;
  logic [DIM_W-1:0] map_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns <= DIM_W'(CFG_RESET);
      map_rows    <= DIM_W'(CFG_RESET);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAP_COLUMNS: map_columns <= cfg_data;
        REG_MAP_ROWS:    map_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline enables, back from the output register
  logic             en_out;
  logic [NPIPE-1:0] en_p;
  logic             en1;
  logic             accept;
  logic             busy;
  logic             s1_valid;
  logic [NPIPE-1:0] pv;

  always_comb begin
    en_out          = !out_valid || out_ready;
    en_p[NPIPE-1]   = !pv[NPIPE-1] || en_out;
    for (int j = NPIPE - 2; j >= 0; j--) begin
      en_p[j] = !pv[j] || en_p[j+1];
    end
    en1 = !s1_valid || en_p[0];
  end

  assign in_ready = !busy && en1;
  assign accept   = in_valid && in_ready;

  // Corner decode from the request
  logic [DIM_W-1:0]        cols_eff;
  logic [DIM_W-1:0]        rows_eff;
  logic signed [ACC_W-1:0] px0;
  logic signed [ACC_W-1:0] py0;
  logic signed [ACC_W-1:0] px1;
  logic signed [ACC_W-1:0] py1;
  logic [ACC_W-1:0]        c0;
  logic [ACC_W-1:0]        c1;
  logic [ACC_W-1:0]        r0;
  logic [ACC_W-1:0]        r1;
  rd_item_t                s1_next;
  map_wr_t                 wr;
  map_rd_t                 rd;

  always_comb begin
    cols_eff = (map_columns > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : map_columns;
    rows_eff = (map_rows > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : map_rows;
    px0 = {{(ACC_W - POS_W){pos_x[POS_W-1]}}, pos_x};
    py0 = {{(ACC_W - POS_W){pos_y[POS_W-1]}}, pos_y};
    px1 = px0 + BOX_FX_A;
    py1 = py0 + BOX_FX_A;
    c0  = px0 >>> TILE_SHIFT;
    c1  = px1 >>> TILE_SHIFT;
    r0  = py0 >>> TILE_SHIFT;
    r1  = py1 >>> TILE_SHIFT;

    s1_next.resolve   = (mode_t'(mode) == MODE_RESOLVE);
    s1_next.px        = px0;
    s1_next.py        = py0;
    s1_next.col0      = c0[IDX_W-1:0];
    s1_next.col1      = c1[IDX_W-1:0];
    s1_next.row0      = r0[IDX_W-1:0];
    s1_next.row1      = r1[IDX_W-1:0];
    s1_next.col_ok[0] = !c0[ACC_W-1] && (c0 < ACC_W'(cols_eff));
    s1_next.col_ok[1] = !c1[ACC_W-1] && (c1 < ACC_W'(cols_eff));
    s1_next.row_ok[0] = !r0[ACC_W-1] && (r0 < ACC_W'(rows_eff));
    s1_next.row_ok[1] = !r1[ACC_W-1] && (r1 < ACC_W'(rows_eff));

    wr.en    = accept && (mode_t'(mode) == MODE_WRITE)
               && (DIM_W'(tile_column) < DIM_W'(MAP_DIM))
               && (DIM_W'(tile_row) < DIM_W'(MAP_DIM));
    wr.row   = tile_row;
    wr.col   = tile_column;
    wr.solid = tile_solid;

    rd.en   = en1;
    rd.row0 = r0[IDX_W-1:0];
    rd.row1 = r1[IDX_W-1:0];
  end

  logic [MAP_DIM-1:0] rdata0;
  logic [MAP_DIM-1:0] rdata1;

  tbcr_map_mem u_map (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd     (rd),
    .rdata0 (rdata0),
    .rdata1 (rdata1),
    .busy   (busy)
  );

  rd_item_t s1;
  item_t    pipe [NPIPE];
  item_t    s2_next;
  item_t    push_next [NPIPE];

  // Hit decode; writes carry zero position and no hits
  always_comb begin
    s2_next.hits[0] = s1.resolve && s1.col_ok[0] && s1.row_ok[0] && rdata0[s1.col0];
    s2_next.hits[1] = s1.resolve && s1.col_ok[1] && s1.row_ok[0] && rdata0[s1.col1];
    s2_next.hits[2] = s1.resolve && s1.col_ok[0] && s1.row_ok[1] && rdata1[s1.col0];
    s2_next.hits[3] = s1.resolve && s1.col_ok[1] && s1.row_ok[1] && rdata1[s1.col1];
    s2_next.hit_count = 3'(s2_next.hits[0]) + 3'(s2_next.hits[1])
                      + 3'(s2_next.hits[2]) + 3'(s2_next.hits[3]);
    s2_next.px     = s1.resolve ? s1.px : '0;
    s2_next.py     = s1.resolve ? s1.py : '0;
    s2_next.off_c0 = OFF_BASE_A - signed'(ACC_W'(s1.col0) << TILE_SHIFT);
    s2_next.off_c1 = OFF_BASE_A - signed'(ACC_W'(s1.col1) << TILE_SHIFT);
    s2_next.off_r0 = OFF_BASE_A - signed'(ACC_W'(s1.row0) << TILE_SHIFT);
    s2_next.off_r1 = OFF_BASE_A - signed'(ACC_W'(s1.row1) << TILE_SHIFT);
  end

  always_comb begin
    push_next[0] = s2_next;
    for (int j = 1; j < NPIPE; j++) begin
      push_next[j] = push_step(pipe[j-1], 2'(j - 1));
    end
  end

  function automatic logic signed [POS_W-1:0] sat_pos(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    if (v > POS_MAX_A) begin
      s = POS_MAX_A;
    end else if (v < POS_MIN_A) begin
      s = POS_MIN_A;
    end else begin
      s = v;
    end
    return s[POS_W-1:0];
  endfunction

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pv        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= accept;
      end
      if (en_p[0]) begin
        pv[0] <= s1_valid;
      end
      for (int j = 1; j < NPIPE; j++) begin
        if (en_p[j]) begin
          pv[j] <= pv[j-1];
        end
      end
      if (en_out) begin
        out_valid <= pv[NPIPE-1];
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= s1_next;
    end
    for (int j = 0; j < NPIPE; j++) begin
      if (en_p[j]) begin
        pipe[j] <= push_next[j];
      end
    end
    if (en_out) begin
      new_x     <= sat_pos(pipe[NPIPE-1].px);
      new_y     <= sat_pos(pipe[NPIPE-1].py);
      collided  <= (pipe[NPIPE-1].hit_count != 3'd0);
      hit_count <= pipe[NPIPE-1].hit_count;
    end
  end

endmodule

FILE: src/tbcr_checker.sv
// Port-level checks for the tile map box collision resolver, bound to the top level.
// Depends on tbcr_pkg.
module tbcr_checker import tbcr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_write,
  input logic [CFG_IDX_W-1:0]    cfg_index,
  input logic [DIM_W-1:0]        cfg_data,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    mode,
  input logic signed [POS_W-1:0] pos_x,
  input logic signed [POS_W-1:0] pos_y,
  input logic [IDX_W-1:0]        tile_column,
  input logic [IDX_W-1:0]        tile_row,
  input logic                    tile_solid,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [POS_W-1:0] new_x,
  input logic signed [POS_W-1:0] new_y,
  input logic                    collided,
  input logic [2:0]              hit_count
);

  // Map clearing pass holds off requests right after reset
  a_clear_blocks_in: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during map clearing pass");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hit_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (collided == (hit_count != 3'd0)) && (hit_count <= 3'd4))
    else $error("collided and hit_count disagree");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_x) && $stable(new_y)
      && $stable(collided) && $stable(hit_count))
    else $error("stalled result changed");

endmodule

bind tilemap_box_collision_resolve tbcr_checker u_checker (.*);

FILE: verif/box_resolve_checker.sv
// Checker for the tile map box collision resolver: watches the config port and
// the request and result channels, predicts every result and compares it field by field.
// Depends on tbcr_pkg for port widths, register codes and request modes.
module box_resolve_checker import tbcr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    mode,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [IDX_W-1:0]        tile_column,
  input  logic [IDX_W-1:0]        tile_row,
  input  logic                    tile_solid,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [POS_W-1:0] new_x,
  input  logic signed [POS_W-1:0] new_y,
  input  logic                    collided,
  input  logic [2:0]              hit_count,
  output int                      mismatch_count,
  output int                      resolutions_pending
);

  localparam int     MAP_SIDE     = 64;
  localparam int     TILE_SHIFT_B = 14;
  localparam longint TILE_SPAN_FX = 64 * 256;
  localparam longint TILE_MID_FX  = 32 * 256;
  localparam longint BOX_SPAN_FX  = 60 * 256;
  localparam longint BOX_HALF_FX  = 30 * 256;
  localparam longint PUSH_DIST_FX = BOX_HALF_FX + TILE_MID_FX;
  localparam longint EDGE_LO      = -(longint'(1) << (POS_W - 1));
  localparam longint EDGE_HI      = (longint'(1) << (POS_W - 1)) - 1;
  localparam logic [DIM_W-1:0] DIM_AT_RESET = 7'd64;

  typedef struct {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    collided;
    logic [2:0]              hits;
  } resolution_t;

  logic             solid_map [MAP_SIDE*MAP_SIDE];
  logic [DIM_W-1:0] used_columns;
  logic [DIM_W-1:0] used_rows;
  resolution_t      expected_resolutions [$];
  int               mismatches = 0;

  task automatic report_mismatch(input string what);
    $display("%0t  %s", $time, what);
    mismatches++;
  endtask

  function automatic resolution_t predict_resolution(input logic signed [POS_W-1:0] left_edge,
                                                     input logic signed [POS_W-1:0] top_edge);
    longint      px, py, cx, cy, col, row, dx, dy, xd, yd, col_lim, row_lim;
    longint      hit_col [4];
    longint      hit_row [4];
    int          hits;
    resolution_t res;
    px      = left_edge;
    py      = top_edge;
    col_lim = (used_columns > MAP_SIDE) ? MAP_SIDE : used_columns;
    row_lim = (used_rows > MAP_SIDE) ? MAP_SIDE : used_rows;
    hits    = 0;
    // Corners in order top-left, top-right, bottom-left, bottom-right
    for (int k = 0; k < 4; k++) begin
      cx  = px + (((k & 1) != 0) ? BOX_SPAN_FX : 0);
      cy  = py + (((k & 2) != 0) ? BOX_SPAN_FX : 0);
      col = cx >>> TILE_SHIFT_B;
      row = cy >>> TILE_SHIFT_B;
      if (col >= 0 && col < col_lim && row >= 0 && row < row_lim &&
          solid_map[row * MAP_SIDE + col]) begin
        hit_col[hits] = col;
        hit_row[hits] = row;
        hits++;
      end
    end
    for (int k = 0; k < hits; k++) begin
      dx = px + BOX_HALF_FX - (hit_col[k] * TILE_SPAN_FX + TILE_MID_FX);
      dy = py + BOX_HALF_FX - (hit_row[k] * TILE_SPAN_FX + TILE_MID_FX);
      xd = PUSH_DIST_FX - ((dx < 0) ? -dx : dx);
      yd = PUSH_DIST_FX - ((dy < 0) ? -dy : dy);
      // Push along the shallower axis; ties go to y
      if (xd > 0 && yd > 0) begin
        if (xd < yd) px += (dx < 0) ? -xd : xd;
        else py += (dy < 0) ? -yd : yd;
      end
    end
    if (px < EDGE_LO) px = EDGE_LO;
    if (px > EDGE_HI) px = EDGE_HI;
    if (py < EDGE_LO) py = EDGE_LO;
    if (py > EDGE_HI) py = EDGE_HI;
    res.x        = POS_W'(px);
    res.y        = POS_W'(py);
    res.collided = (hits != 0);
    res.hits     = 3'(hits);
    return res;
  endfunction

  always @(posedge clk) begin
    resolution_t want;
    if (rst) begin
      expected_resolutions.delete();
      for (int i = 0; i < MAP_SIDE * MAP_SIDE; i++) solid_map[i] = 1'b0;
      used_columns = DIM_AT_RESET;
      used_rows    = DIM_AT_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_COLUMNS: used_columns = cfg_data;
          REG_MAP_ROWS:    used_rows    = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_resolutions.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: x=%0d y=%0d",
                                    new_x, new_y));
        end else begin
          want = expected_resolutions.pop_front();
          if (new_x !== want.x)
            report_mismatch($sformatf("new_x: got %0d, want %0d", new_x, want.x));
          if (new_y !== want.y)
            report_mismatch($sformatf("new_y: got %0d, want %0d", new_y, want.y));
          if (collided !== want.collided)
            report_mismatch($sformatf("collided: got %0b, want %0b", collided, want.collided));
          if (hit_count !== want.hits)
            report_mismatch($sformatf("hit_count: got %0d, want %0d", hit_count, want.hits));
        end
      end
      if (in_valid && in_ready) begin
        if (mode_t'(mode) == MODE_WRITE) begin
          solid_map[int'(tile_row) * MAP_SIDE + int'(tile_column)] = tile_solid;
          want = '{x: '0, y: '0, collided: 1'b0, hits: 3'd0};
        end else begin
          want = predict_resolution(pos_x, pos_y);
        end
        // Append at the tail
        expected_resolutions = {expected_resolutions, want};
      end
    end
    resolutions_pending <= expected_resolutions.size();
    mismatch_count      <= mismatches;
  end

endmodule

FILE: verif/tb_tilemap_box_collision_resolve.sv
// Testbench top for the tile map box collision resolver: clock, reset, request
// stimulus with random idling and back-pressure, and the final verdict.
// Depends on tbcr_pkg, the block and box_resolve_checker.
module tb_tilemap_box_collision_resolve;
  import tbcr_pkg::*;

  localparam int MAP_SIDE        = 64;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int LONG_HOLD       = 80;
  localparam int SETTLE_CYCLES   = 10;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int POS_TOP         = (1 << (POS_W - 1)) - 1;
  localparam int PHASE_COLS [PHASES] = '{64, 1, 0, 127, 13, 64, 100, 40};
  localparam int PHASE_ROWS [PHASES] = '{64, 1, 64, 127, 40, 0, 70, 64};

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    cfg_write   = 1'b0;
  cfg_reg_t                cfg_index   = REG_MAP_COLUMNS;
  logic [DIM_W-1:0]        cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_ready;
  mode_t                   mode        = MODE_WRITE;
  logic signed [POS_W-1:0] pos_x       = '0;
  logic signed [POS_W-1:0] pos_y       = '0;
  logic [IDX_W-1:0]        tile_column = '0;
  logic [IDX_W-1:0]        tile_row    = '0;
  logic                    tile_solid  = 1'b0;
  logic                    out_valid;
  logic                    out_ready   = 1'b0;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic                    collided;
  logic [2:0]              hit_count;

  int   mismatch_count;
  int   resolutions_pending;
  int   cycle_count  = 0;
  logic sender_gaps  = 1'b1;
  logic ready_gaps   = 1'b1;
  logic hold_output  = 1'b0;

  tilemap_box_collision_resolve DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .pos_x, .pos_y, .tile_column, .tile_row, .tile_solid,
    .out_valid, .out_ready, .new_x, .new_y, .collided, .hit_count
  );

  box_resolve_checker u_checker (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .pos_x, .pos_y, .tile_column, .tile_row, .tile_solid,
    .out_valid, .out_ready, .new_x, .new_y, .collided, .hit_count,
    .mismatch_count, .resolutions_pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tilemap_box_collision_resolve verification failed");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 14) return $urandom_range(1, 3);
    if (roll < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [POS_W-1:0] fx(input int pixels, input int frac);
    return POS_W'(pixels * 256 + frac);
  endfunction

  // Receiver: random stalls, plus one long hold on request from the stimulus
  initial begin
    forever begin
      @(posedge clk);
      if (hold_output) begin
        hold_output = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (ready_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input mode_t m, input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y, input logic [IDX_W-1:0] col,
                              input logic [IDX_W-1:0] row, input logic solid);
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    pos_x       <= x;
    pos_y       <= y;
    tile_column <= col;
    tile_row    <= row;
    tile_solid  <= solid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_tile(input int col, input int row, input logic solid);
    send_request(MODE_WRITE, POS_W'($urandom()), POS_W'($urandom()), IDX_W'(col),
                 IDX_W'(row), solid);
  endtask

  task automatic resolve_box(input logic signed [POS_W-1:0] x,
                             input logic signed [POS_W-1:0] y);
    send_request(MODE_RESOLVE, x, y, IDX_W'($urandom()), IDX_W'($urandom()),
                 1'($urandom_range(0, 1)));
  endtask

  // Wait until every result is back, then let the pipeline settle
  task automatic wait_drain();
    do @(posedge clk); while (resolutions_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dims(input int cols, input int rows);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAP_COLUMNS;
    cfg_data  <= DIM_W'(cols);
    @(posedge clk);
    cfg_index <= REG_MAP_ROWS;
    cfg_data  <= DIM_W'(rows);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(input int lim);
    if (lim > 0 && $urandom_range(0, 3) != 0) return IDX_W'($urandom_range(0, lim - 1));
    return IDX_W'($urandom_range(0, MAP_SIDE - 1));
  endfunction

  // Position from one tile before the map to one tile past the tiles in use
  function automatic logic signed [POS_W-1:0] near_coord(input int lim);
    int lo, hi, v;
    lo = -64 * 256;
    hi = (lim * 64 + 64) * 256;
    v  = lo + int'($urandom_range(0, hi - lo));
    if (v > POS_TOP) v = POS_TOP;
    return POS_W'(v);
  endfunction

  task automatic send_random_item(input int cols, input int rows);
    int lim_c, lim_r;
    lim_c = (cols > MAP_SIDE) ? MAP_SIDE : cols;
    lim_r = (rows > MAP_SIDE) ? MAP_SIDE : rows;
    if ($urandom_range(0, 9) < 3)
      write_tile(pick_index(lim_c), pick_index(lim_r), 1'($urandom_range(0, 1)));
    else if ($urandom_range(0, 4) == 0)
      resolve_box(POS_W'($urandom()), POS_W'($urandom()));
    else
      resolve_box(near_coord(lim_c), near_coord(lim_r));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty map at the position extremes
    resolve_box(fx(-4096, 0), fx(-4096, 0));
    resolve_box(fx(4095, 255), fx(4095, 255));
    resolve_box(fx(0, 0), fx(0, 0));
    // All four corners in one solid tile, then left corners off the map
    write_tile(0, 0, 1'b1);
    resolve_box(fx(0, 0), fx(0, 0));
    resolve_box(fx(-20, 128), fx(10, 0));
    // Four distinct solid tiles
    write_tile(1, 1, 1'b1);
    write_tile(2, 1, 1'b1);
    write_tile(1, 2, 1'b1);
    write_tile(2, 2, 1'b1);
    resolve_box(fx(100, 64), fx(100, 192));
    // Box centred on a tile, then on its diagonal: both are ties
    write_tile(5, 5, 1'b1);
    resolve_box(fx(322, 0), fx(322, 0));
    resolve_box(fx(300, 0), fx(300, 0));
    // Pushes past the top of the position range saturate
    write_tile(63, 10, 1'b1);
    resolve_box(fx(4090, 0), fx(642, 0));
    write_tile(10, 63, 1'b1);
    resolve_box(fx(642, 0), fx(4090, 0));
    // Far corner tile, and a tile cleared back to open
    write_tile(63, 63, 1'b1);
    write_tile(0, 0, 1'b0);
    resolve_box(fx(0, 0), fx(0, 0));
    resolve_box(fx(4050, 37), fx(4050, 200));
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      write_dims(PHASE_COLS[p], PHASE_ROWS[p]);
      sender_gaps = (p != 0 && p != 3);
      ready_gaps  = (p != 0);
      // Hold the output long enough to back the pipeline up into in_ready
      if (p == 3) hold_output = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random_item(PHASE_COLS[p], PHASE_ROWS[p]);
      in_valid <= 1'b0;
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && resolutions_pending == 0) begin
      $display("tilemap_box_collision_resolve verification clean");
    end else begin
      $display("tilemap_box_collision_resolve verification failed");
    end
    $finish;
  end

endmodule
